@@ hdl/mtt_pkg.sv @@
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared widths and defaults for the motor telemetry tracker.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam int MotorCountDef = 4;
  localparam int TickBitsDef   = 9;

  localparam int IdxW   = 2;
  localparam int VoltW  = 16;
  localparam int WordW  = 16;
  localparam int LoadW  = 7;
  localparam int TickW  = 16;
  localparam int HistN  = 3;

  typedef logic signed [VoltW-1:0] volt_t;
  typedef logic signed [TickW-1:0] tick_t;

endpackage

@@ hdl/mtt_median3.sv @@
// ----------------------------------------------------------------------------
// mtt_median3
// Signed median of three voltage samples, one comparator network.
// ----------------------------------------------------------------------------
module mtt_median3 (
  input  mtt_pkg::volt_t a_i,
  input  mtt_pkg::volt_t b_i,
  input  mtt_pkg::volt_t c_i,
  output mtt_pkg::volt_t med_o
);

  mtt_pkg::volt_t hi, lo;

  always_comb begin
    hi = (a_i < b_i) ? b_i : a_i;
    lo = (a_i < b_i) ? a_i : b_i;
    if (c_i >= hi) begin
      med_o = hi;
    end else if (c_i <= lo) begin
      med_o = lo;
    end else begin
      med_o = c_i;
    end
  end

endmodule

@@ hdl/motor_telemetry_tracker.sv @@
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled; the per-motor state is read and written in one pass.
// Back-to-back items on the same motor see the state left by the previous item.
// Reset (rst_ni low, asynchronous): histories, online flags, tick counters and
// the overflow flag clear to zero; both pipeline stages empty.
// ----------------------------------------------------------------------------
// motor_telemetry_tracker
// Per-motor median-of-three voltage supervisor with a tick accumulator.
// ----------------------------------------------------------------------------
module motor_telemetry_tracker #(
  parameter int MOTOR_COUNT = mtt_pkg::MotorCountDef,
  parameter int TICK_BITS   = mtt_pkg::TickBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mtt_pkg::IdxW-1:0]    motor_index_i,
  input  mtt_pkg::volt_t              voltage_sample_i,
  input  logic                        controller_done_i,
  input  logic [mtt_pkg::WordW-1:0]   report_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mtt_pkg::IdxW-1:0]    motor_tag_o,
  output logic                        online_o,
  output mtt_pkg::volt_t              median_voltage_o,
  output logic [mtt_pkg::LoadW-1:0]   load_o,
  output mtt_pkg::tick_t              tick_count_o,
  output logic                        tick_overflow_o
);

  // input stage
  logic                       s1_valid_q, s1_valid_d;
  logic [mtt_pkg::IdxW-1:0]   s1_idx_q;
  mtt_pkg::volt_t             s1_volt_q;
  logic                       s1_done_q;
  logic [mtt_pkg::WordW-1:0]  s1_word_q;

  // result stage
  logic                       out_valid_q, out_valid_d;
  logic [mtt_pkg::IdxW-1:0]   out_id_q;
  logic                       out_online_q;
  mtt_pkg::volt_t             out_med_q;
  logic [mtt_pkg::LoadW-1:0]  out_load_q;
  mtt_pkg::tick_t             out_tick_q;
  logic                       out_ovf_q;

  // per-motor state
  mtt_pkg::volt_t hist_q   [MOTOR_COUNT][mtt_pkg::HistN];
  logic           online_q [MOTOR_COUNT];
  mtt_pkg::tick_t tick_q   [MOTOR_COUNT];
  logic           ovf_q, ovf_d;

  logic out_free, in_accept, do_step;

  logic                       hit;
  mtt_pkg::volt_t             sel_h0, sel_h1;
  logic                       sel_online;
  mtt_pkg::tick_t             sel_tick;
  mtt_pkg::volt_t             sample;
  mtt_pkg::volt_t             med;
  logic                       now_online;
  logic [mtt_pkg::WordW-1:0]  word_g;
  logic [mtt_pkg::LoadW-1:0]  load;
  logic signed [mtt_pkg::TickW:0] inc, sum;
  logic                       sum_ovf;
  mtt_pkg::tick_t             tick_n;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign do_step    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept ? 1'b1 : (do_step ? 1'b0 : s1_valid_q);
  assign out_valid_d = do_step ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  // select the addressed motor's state
  always_comb begin
    hit        = 1'b0;
    sel_h0     = '0;
    sel_h1     = '0;
    sel_online = 1'b0;
    sel_tick   = '0;
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      if (32'(s1_idx_q) == m) begin
        hit        = 1'b1;
        sel_h0     = hist_q[m][0];
        sel_h1     = hist_q[m][1];
        sel_online = online_q[m];
        sel_tick   = tick_q[m];
      end
    end
  end

  assign sample = s1_done_q ? s1_volt_q : '0;

  mtt_median3 u_median (
    .a_i   (sample),
    .b_i   (sel_h0),
    .c_i   (sel_h1),
    .med_o (med)
  );

  assign now_online = s1_done_q && (med != '0) && (med != '1);

  // drop the report word while the motor was offline
  assign word_g  = sel_online ? s1_word_q : '0;
  assign load    = mtt_pkg::LoadW'(word_g >> TICK_BITS);
  assign inc     = (mtt_pkg::TickW+1)'($signed(word_g[TICK_BITS-1:0]));
  assign sum     = {sel_tick[mtt_pkg::TickW-1], sel_tick} + inc;
  assign sum_ovf = sum[mtt_pkg::TickW] ^ sum[mtt_pkg::TickW-1];
  assign tick_n  = sum_ovf ? sel_tick : sum[mtt_pkg::TickW-1:0];
  assign ovf_d   = ovf_q | (hit & sum_ovf);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ovf_q       <= 1'b0;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        for (int k = 0; k < mtt_pkg::HistN; k++) begin
          hist_q[m][k] <= '0;
        end
        online_q[m] <= 1'b0;
        tick_q[m]   <= '0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (do_step) begin
        ovf_q <= ovf_d;
      end
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        if (do_step && 32'(s1_idx_q) == m) begin
          hist_q[m][2] <= hist_q[m][1];
          hist_q[m][1] <= hist_q[m][0];
          hist_q[m][0] <= sample;
          online_q[m]  <= now_online;
          tick_q[m]    <= tick_n;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_idx_q  <= motor_index_i;
      s1_volt_q <= voltage_sample_i;
      s1_done_q <= controller_done_i;
      s1_word_q <= report_word_i;
    end
    if (do_step) begin
      out_id_q     <= s1_idx_q;
      out_online_q <= hit & now_online;
      out_med_q    <= hit ? med : '0;
      out_load_q   <= hit ? load : '0;
      out_tick_q   <= hit ? tick_n : '0;
      out_ovf_q    <= ovf_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign motor_tag_o      = out_id_q;
  assign online_o         = out_online_q;
  assign median_voltage_o = out_med_q;
  assign load_o           = out_load_q;
  assign tick_count_o     = out_tick_q;
  assign tick_overflow_o  = out_ovf_q;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input stage");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_step |=> out_valid_q)
    else $error("advanced item did not reach result register");

  a_online_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_online_q) |-> (out_med_q != '0 && out_med_q != '1))
    else $error("online reported with invalid median");

  a_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && 32'(out_id_q) >= MOTOR_COUNT) |->
      (!out_online_q && out_tick_q == '0 && out_load_q == '0))
    else $error("out-of-range motor produced state");
`endif

endmodule
